// ===== rtl/midi_track_note_event_parser_core_defines.svh =====
// Assertion macros used by the checker file of the track event parser.
`ifndef MIDI_TRACK_NOTE_EVENT_PARSER_CORE_DEFINES_SVH
`define MIDI_TRACK_NOTE_EVENT_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, off while reset is asserted.
`define MTNEP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, off while reset is asserted.
`define MTNEP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/mtnep_pkg.sv =====
// Package with the event type and field widths of the track event parser.
package mtnep_pkg;

	localparam int TickW = 32;
	localparam int NoteW = 7;
	localparam int VlqW  = 28;

	typedef struct packed {
		logic             valid;
		logic [TickW-1:0] tick;
		logic [NoteW-1:0] note_number;
		logic             pressed;
	} note_evt_t;

endpackage

// ===== rtl/mtnep_parser.sv =====
// Byte-wise track parser state and its combinational next-state logic.
module mtnep_parser (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  take,
	input  logic [7:0]            track_byte,
	input  logic                  end_of_track,
	output mtnep_pkg::note_evt_t  evt
);

	localparam logic [2:0] PH_DELTA     = 3'd0;
	localparam logic [2:0] PH_STATUS    = 3'd1;
	localparam logic [2:0] PH_DATA      = 3'd2;
	localparam logic [2:0] PH_META_TYPE = 3'd3;
	localparam logic [2:0] PH_LEN       = 3'd4;
	localparam logic [2:0] PH_SKIP      = 3'd5;

	localparam logic [3:0] KIND_OFF  = 4'h8;
	localparam logic [3:0] KIND_ON   = 4'h9;
	localparam logic [3:0] KIND_PROG = 4'hC;
	localparam logic [3:0] KIND_PRES = 4'hD;
	localparam logic [3:0] KIND_SYS  = 4'hF;
	localparam logic [7:0] ST_META   = 8'hFF;
	localparam logic [7:0] ST_SYSEX  = 8'hF0;
	localparam logic [7:0] ST_ESC    = 8'hF7;

	logic [2:0]                 phase_q, phase_d;
	logic [mtnep_pkg::TickW-1:0] tick_q, tick_d;
	logic [mtnep_pkg::VlqW-1:0]  delta_q, delta_d;
	logic [7:0]                 rs_q, rs_d;
	logic [1:0]                 left_q, left_d;
	logic [mtnep_pkg::NoteW-1:0] held_q, held_d;
	logic [mtnep_pkg::VlqW-1:0]  skip_q, skip_d;
	logic                       halt_q, halt_d;
	logic [mtnep_pkg::VlqW-1:0]  delta_sh, skip_sh, skip_dec;
	logic [3:0]                 rs_kind, b_kind;

	assign delta_sh = {delta_q[mtnep_pkg::VlqW-8:0], track_byte[6:0]};
	assign skip_sh  = {skip_q[mtnep_pkg::VlqW-8:0], track_byte[6:0]};
	assign skip_dec = skip_q - mtnep_pkg::VlqW'(1);
	assign rs_kind  = rs_q[7:4];
	assign b_kind   = track_byte[7:4];

	always_comb begin
		phase_d = phase_q;
		tick_d  = tick_q;
		delta_d = delta_q;
		rs_d    = rs_q;
		left_d  = left_q;
		held_d  = held_q;
		skip_d  = skip_q;
		halt_d  = halt_q;
		evt     = '0;
		evt.tick        = tick_q;
		evt.note_number = held_q;
		evt.pressed     = (rs_kind == KIND_ON);
		if (!halt_q) begin
			case (phase_q)
				PH_STATUS: begin
					if (!track_byte[7]) begin
						if (rs_q[7] && rs_kind != KIND_SYS) begin
							if (rs_kind == KIND_PROG || rs_kind == KIND_PRES) begin
								left_d  = 2'd0;
								phase_d = PH_DELTA;
							end else begin
								held_d  = track_byte[6:0];
								left_d  = 2'd1;
								phase_d = PH_DATA;
							end
						end else begin
							phase_d = PH_DELTA;
						end
					end else if (b_kind != KIND_SYS) begin
						rs_d    = track_byte;
						left_d  = (b_kind == KIND_PROG || b_kind == KIND_PRES) ? 2'd1 : 2'd2;
						phase_d = PH_DATA;
					end else if (track_byte == ST_META) begin
						rs_d    = '0;
						phase_d = PH_META_TYPE;
					end else if (track_byte == ST_SYSEX || track_byte == ST_ESC) begin
						rs_d    = '0;
						skip_d  = '0;
						phase_d = PH_LEN;
					end else begin
						halt_d = 1'b1;
					end
				end
				PH_DATA: begin
					if (left_q == 2'd2) begin
						held_d = track_byte[6:0];
						left_d = 2'd1;
					end else begin
						left_d    = 2'd0;
						phase_d   = PH_DELTA;
						evt.valid = (rs_kind == KIND_OFF || rs_kind == KIND_ON);
					end
				end
				PH_META_TYPE: begin
					skip_d  = '0;
					phase_d = PH_LEN;
				end
				PH_LEN: begin
					skip_d = skip_sh;
					if (!track_byte[7]) begin
						phase_d = (skip_sh == '0) ? PH_DELTA : PH_SKIP;
					end
				end
				PH_SKIP: begin
					skip_d = skip_dec;
					if (skip_dec == '0) begin
						phase_d = PH_DELTA;
					end
				end
				default: begin
					if (!track_byte[7]) begin
						tick_d  = tick_q + mtnep_pkg::TickW'(delta_sh);
						delta_d = '0;
						phase_d = PH_STATUS;
					end else begin
						delta_d = delta_sh;
						phase_d = PH_DELTA;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_DELTA;
			tick_q  <= '0;
			delta_q <= '0;
			rs_q    <= '0;
			left_q  <= '0;
			held_q  <= '0;
			skip_q  <= '0;
			halt_q  <= 1'b0;
		end else if (take) begin
			if (end_of_track) begin
				phase_q <= PH_DELTA;
				tick_q  <= '0;
				delta_q <= '0;
				rs_q    <= '0;
				left_q  <= '0;
				held_q  <= '0;
				skip_q  <= '0;
				halt_q  <= 1'b0;
			end else begin
				phase_q <= phase_d;
				tick_q  <= tick_d;
				delta_q <= delta_d;
				rs_q    <= rs_d;
				left_q  <= left_d;
				held_q  <= held_d;
				skip_q  <= skip_d;
				halt_q  <= halt_d;
			end
		end
	end

endmodule

// ===== rtl/midi_track_note_event_parser_core.sv =====
// Top level of the track note event parser: stream ports and result register.
//
// Channel  Dir  Fields (tdata low bit up)               Side fields
// s_       in   track_byte[7:0]                         tlast = end_of_track
// m_       out  tick[31:0], note_number[38:32], pad[39] tuser = pressed
//
// One byte is accepted per clock while s_tready is high and is parsed in
// that cycle; a completed note event is on the master side next cycle.
// The only stall path is the result register: s_tready drops while an
// event waits and m_tready is low. Reset clears all parser state and the
// result valid flag; tlast on a byte clears the state after that byte.
module midi_track_note_event_parser_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // track_byte[7:0]
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // tick[31:0], note_number[38:32], zero[39]
	output logic        m_tuser    // pressed
);

	mtnep_pkg::note_evt_t evt;
	logic                 take;
	logic                 out_v_q;
	logic [39:0]          out_data_q;
	logic                 out_user_q;

	assign s_tready = !out_v_q || m_tready;
	assign take     = s_tvalid && s_tready;

	mtnep_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.track_byte   (s_tdata),
		.end_of_track (s_tlast),
		.evt          (evt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (s_tready) begin
			out_v_q <= take && evt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take && evt.valid && s_tready) begin
			out_data_q <= {1'b0, evt.note_number, evt.tick};
			out_user_q <= evt.pressed;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

endmodule

// ===== rtl/mtnep_checker.sv =====
// Port-level checker for the track note event parser, bound to the top level.
`include "midi_track_note_event_parser_core_defines.svh"

module mtnep_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,
	input  logic        m_tuser
);

	`MTNEP_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
	`MTNEP_ASSERT_SAME(a_ready_when_empty, clk, arst_n, !m_tvalid, s_tready)
	`MTNEP_ASSERT_SAME(a_new_event_from_byte, clk, arst_n, $rose(m_tvalid), $past(s_tvalid && s_tready))
	`MTNEP_ASSERT_SAME(a_pad_zero, clk, arst_n, m_tvalid, m_tdata[39] == 1'b0)

endmodule

bind midi_track_note_event_parser_core mtnep_checker u_mtnep_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// ===== tb/tb_midi_track_note_event_parser_core.sv =====
// Testbench for the track note event parser: random MIDI tracks checked against a local parser.
module tb_midi_track_note_event_parser_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TickW = mtnep_pkg::TickW;
	localparam int NoteW = mtnep_pkg::NoteW;
	localparam int VlqW  = mtnep_pkg::VlqW;

	typedef mtnep_pkg::note_evt_t note_evt_t;

	typedef enum logic [2:0] {
		WAIT_DELTA,
		WAIT_STATUS,
		WAIT_DATA,
		WAIT_META_TYPE,
		WAIT_LENGTH,
		SKIP_BODY
	} parse_state_e;

	localparam logic [7:0] NOTE_OFF      = 8'h80;
	localparam logic [7:0] NOTE_ON       = 8'h90;
	localparam logic [7:0] POLY_PRESSURE = 8'hA0;
	localparam logic [7:0] CONTROL       = 8'hB0;
	localparam logic [7:0] PROGRAM       = 8'hC0;
	localparam logic [7:0] CHAN_PRESSURE = 8'hD0;
	localparam logic [7:0] PITCH_BEND    = 8'hE0;
	localparam logic [7:0] SYSEX         = 8'hF0;
	localparam logic [7:0] SYSEX_ESCAPE  = 8'hF7;
	localparam logic [7:0] META          = 8'hFF;
	localparam logic [7:0] KIND_MASK     = 8'hF0;
	localparam logic [3:0] SYSTEM_NIBBLE = 4'hF;

	localparam int IdleLimit   = 2000;
	localparam int HoldCycles  = 400;
	localparam int DrainCycles = 6;
	localparam int PhaseItems  = 300;

	typedef struct packed {
		logic [7:0] data;
		logic       eot;
	} track_item_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'h00;
	logic        s_tlast  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic        m_tuser;

	midi_track_note_event_parser_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	track_item_t track_q[$];
	track_item_t gen_q[$];
	note_evt_t   note_q[$];
	track_item_t cur;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit stall_req     = 1'b0;
	bit stall_seen    = 1'b0;
	int hold_left     = 0;
	bit in_taken      = 1'b0;
	int fail_count    = 0;
	int quiet_cycles  = 0;

	parse_state_e     ps_state;
	logic [TickW-1:0] ps_tick;
	logic [VlqW-1:0]  ps_delta;
	logic [7:0]       ps_running;
	logic [1:0]       ps_left;
	logic [NoteW-1:0] ps_note;
	logic [VlqW-1:0]  ps_skip;
	logic             ps_halted;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic void clear_parser();
		ps_state   = WAIT_DELTA;
		ps_tick    = '0;
		ps_delta   = '0;
		ps_running = '0;
		ps_left    = '0;
		ps_note    = '0;
		ps_skip    = '0;
		ps_halted  = 1'b0;
	endfunction

	function automatic void take_data_byte(input logic [7:0] b);
		note_evt_t  ev;
		logic [7:0] kind;
		kind = ps_running & KIND_MASK;
		if (ps_left == 2'd2) begin
			ps_note = b[6:0];
			ps_left = 2'd1;
		end else begin
			ps_left  = 2'd0;
			ps_state = WAIT_DELTA;
			if (kind == NOTE_OFF || kind == NOTE_ON) begin
				ev.valid       = 1'b1;
				ev.tick        = ps_tick;
				ev.note_number = ps_note;
				ev.pressed     = (kind == NOTE_ON);
				note_q.push_back(ev);
			end
		end
	endfunction

	function automatic void open_channel(input logic [7:0] st);
		logic [7:0] kind;
		kind       = st & KIND_MASK;
		ps_running = st;
		ps_left    = (kind == PROGRAM || kind == CHAN_PRESSURE) ? 2'd1 : 2'd2;
		ps_state   = WAIT_DATA;
	endfunction

	function automatic void parse_track_byte(input logic [7:0] b, input logic eot);
		if (!ps_halted) begin
			case (ps_state)
				WAIT_STATUS: begin
					if (!b[7]) begin
						if (ps_running[7] && ps_running[7:4] != SYSTEM_NIBBLE) begin
							open_channel(ps_running);
							take_data_byte(b);
						end else begin
							ps_state = WAIT_DELTA;
						end
					end else if (b[7:4] != SYSTEM_NIBBLE) begin
						open_channel(b);
					end else if (b == META) begin
						ps_running = '0;
						ps_state   = WAIT_META_TYPE;
					end else if (b == SYSEX || b == SYSEX_ESCAPE) begin
						ps_running = '0;
						ps_skip    = '0;
						ps_state   = WAIT_LENGTH;
					end else begin
						ps_halted = 1'b1;
					end
				end
				WAIT_DATA: take_data_byte(b);
				WAIT_META_TYPE: begin
					ps_skip  = '0;
					ps_state = WAIT_LENGTH;
				end
				WAIT_LENGTH: begin
					ps_skip = {ps_skip[VlqW-8:0], b[6:0]};
					if (!b[7])
						ps_state = (ps_skip == '0) ? WAIT_DELTA : SKIP_BODY;
				end
				SKIP_BODY: begin
					ps_skip = ps_skip - VlqW'(1);
					if (ps_skip == '0)
						ps_state = WAIT_DELTA;
				end
				default: begin
					ps_delta = {ps_delta[VlqW-8:0], b[6:0]};
					if (!b[7]) begin
						ps_tick  = ps_tick + TickW'(ps_delta);
						ps_delta = '0;
						ps_state = WAIT_STATUS;
					end else begin
						ps_state = WAIT_DELTA;
					end
				end
			endcase
		end
		if (eot)
			clear_parser();
	endfunction

	task automatic put_byte(input logic [7:0] b);
		track_item_t it;
		it.data = b;
		it.eot  = 1'b0;
		gen_q.push_back(it);
	endtask

	task automatic put_vlq(input logic [27:0] v, input int pad, input bit junk);
		logic [6:0] grp [4];
		int         top;
		for (int i = 0; i < 4; i++)
			grp[i] = v[7*i +: 7];
		top = 0;
		for (int i = 1; i < 4; i++)
			if (grp[i] != 7'd0)
				top = i;
		repeat (pad)
			put_byte({1'b1, junk ? 7'($urandom_range(127)) : 7'd0});
		for (int i = top; i > 0; i--)
			put_byte({1'b1, grp[i]});
		put_byte({1'b0, grp[0]});
	endtask

	task automatic flush_track();
		track_item_t it;
		it     = gen_q.pop_back();
		it.eot = 1'b1;
		gen_q.push_back(it);
		foreach (gen_q[i])
			track_q.push_back(gen_q[i]);
		gen_q.delete();
	endtask

	function automatic logic [27:0] pick_delta(input bit wide);
		int r;
		r = $urandom_range(99);
		if (wide)
			return {1'b1, 27'($urandom)};
		if (r < 50)
			return '0;
		if (r < 80)
			return 28'($urandom_range(127));
		if (r < 95)
			return 28'($urandom_range(16383));
		return 28'($urandom);
	endfunction

	task automatic build_track(output int counted);
		int         events;
		int         pick;
		int         len;
		int         live;
		int         cut;
		bit         wide;
		bit         have_run;
		logic [7:0] st;
		gen_q.delete();
		wide     = ($urandom_range(9) == 0);
		events   = wide ? $urandom_range(24, 16) : $urandom_range(12, 1);
		have_run = 1'b0;
		live     = -1;
		for (int e = 0; e < events; e++) begin
			put_vlq(pick_delta(wide), ($urandom_range(9) == 0) ? $urandom_range(2, 1) : 0,
				$urandom_range(3) == 0);
			pick = $urandom_range(99);
			if (pick < 45) begin
				st = ($urandom_range(1) ? NOTE_ON : NOTE_OFF) | 8'($urandom_range(15));
				if (!have_run || $urandom_range(2) == 0)
					put_byte(st);
				put_byte(8'($urandom_range(127)));
				put_byte(($urandom_range(15) == 0) ? 8'($urandom_range(255, 128))
					: 8'($urandom_range(127)));
				have_run = 1'b1;
			end else if (pick < 60) begin
				case ($urandom_range(4))
					0: st = POLY_PRESSURE;
					1: st = CONTROL;
					2: st = PITCH_BEND;
					3: st = PROGRAM;
					default: st = CHAN_PRESSURE;
				endcase
				put_byte(st | 8'($urandom_range(15)));
				put_byte(8'($urandom_range(127)));
				if (st != PROGRAM && st != CHAN_PRESSURE)
					put_byte(8'($urandom_range(127)));
				have_run = 1'b1;
			end else if (pick < 78) begin
				len = $urandom_range(4);
				if (pick < 68) begin
					put_byte(META);
					put_byte(8'($urandom_range(127)));
				end else begin
					put_byte($urandom_range(1) ? SYSEX : SYSEX_ESCAPE);
				end
				put_vlq(28'(len), ($urandom_range(3) == 0) ? 1 : 0, 1'b0);
				repeat (len)
					put_byte(8'($urandom));
				have_run = 1'b0;
			end else if (pick < 84) begin
				put_byte(8'($urandom_range(127)));
			end else if (pick < 88) begin
				st = {SYSTEM_NIBBLE, 4'($urandom_range(14, 1))};
				if (st == SYSEX_ESCAPE)
					st = st + 8'd1;
				put_byte(st);
				live = gen_q.size();
				repeat ($urandom_range(4, 1))
					put_byte(8'($urandom));
				break;
			end else begin
				repeat ($urandom_range(3, 1))
					put_byte(8'($urandom));
			end
		end
		if ($urandom_range(6) == 0) begin
			cut = $urandom_range(gen_q.size(), 1);
			while (gen_q.size() > cut)
				void'(gen_q.pop_back());
		end
		counted = (live >= 0 && live < gen_q.size()) ? live : gen_q.size();
		flush_track();
	endtask

	task automatic run_phase(input int items);
		int sent;
		int n;
		sent = 0;
		while (sent < items) begin
			build_track(n);
			sent += n;
		end
		while (track_q.size() != 0 || s_tvalid)
			@(posedge clk);
		while (note_q.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || in_taken) begin
			if (track_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				cur = track_q.pop_front();
				s_tdata  <= cur.data;
				s_tlast  <= cur.eot;
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (stall_req && !stall_seen) begin
			stall_seen <= 1'b1;
			hold_left  <= HoldCycles;
			m_tready   <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		note_evt_t ev;
		if (arst_n) begin
			in_taken <= s_tvalid && s_tready;
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (s_tvalid && s_tready)
				parse_track_byte(s_tdata, s_tlast);
			if (m_tvalid && m_tready) begin
				if (note_q.size() == 0) begin
					$error("note event with none pending: tick %0h note %0d pressed %0b",
						m_tdata[TickW-1:0], m_tdata[TickW +: NoteW], m_tuser);
					fail_count++;
				end else begin
					ev = note_q.pop_front();
					if (m_tdata[TickW-1:0] !== ev.tick) begin
						$error("tick: expected %0h, got %0h", ev.tick, m_tdata[TickW-1:0]);
						fail_count++;
					end
					if (m_tdata[TickW +: NoteW] !== ev.note_number) begin
						$error("note_number: expected %0d, got %0d", ev.note_number,
							m_tdata[TickW +: NoteW]);
						fail_count++;
					end
					if (m_tuser !== ev.pressed) begin
						$error("pressed: expected %0b, got %0b", ev.pressed, m_tuser);
						fail_count++;
					end
					if (m_tdata[TickW+NoteW] !== 1'b0) begin
						$error("pad: expected 0, got %0b", m_tdata[TickW+NoteW]);
						fail_count++;
					end
				end
			end
		end
	end

	always @(negedge clk) begin
		if (quiet_cycles >= IdleLimit) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		clear_parser();
		send_idle_pct = 20;
		recv_idle_pct = 63;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Opening track: plain note-on, running status with zero velocity, largest delta,
		// status byte as velocity, empty meta, stray data byte, sysex, then a halt.
		put_byte(8'h00);
		put_byte(NOTE_ON);
		put_byte(8'h3C);
		put_byte(8'h40);
		put_byte(8'h7F);
		put_byte(8'h3C);
		put_byte(8'h00);
		put_vlq(28'h0FFFFFFF, 0, 1'b0);
		put_byte(NOTE_OFF | 8'h0F);
		put_byte(8'h7F);
		put_byte(8'hFF);
		put_byte(8'h00);
		put_byte(META);
		put_byte(8'h2F);
		put_byte(8'h00);
		put_byte(8'h00);
		put_byte(8'h3C);
		put_byte(8'h00);
		put_byte(SYSEX);
		put_byte(8'h01);
		put_byte(8'h55);
		put_byte(8'h00);
		put_byte({SYSTEM_NIBBLE, 4'h4});
		put_byte(NOTE_ON);
		flush_track();
		run_phase(PhaseItems);

		send_idle_pct = 63;
		recv_idle_pct = 20;
		run_phase(PhaseItems);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		stall_req     = 1'b1;
		run_phase(PhaseItems);

		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
